### sv/vfvs_pkg.sv
`timescale 1ns / 1ps
// vfvs_pkg: shared types and constants for the voxel face visibility store.
// Depends on nothing; imported by every module of the block.
package vfvs_pkg;

   // Operation codes carried in req_tuser.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam int COORD_W     = 6;
   localparam int BT_W        = 3;
   localparam int MASK_W      = 6;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 16;

   // Face bits of the result mask.
   localparam int FACE_YM = 0;
   localparam int FACE_YP = 1;
   localparam int FACE_XM = 2;
   localparam int FACE_XP = 3;
   localparam int FACE_ZP = 4;
   localparam int FACE_ZM = 5;

   // Command queue between front and back.
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic               op;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic [BT_W-1:0]    block_type;
   } cmd_type;

   typedef struct packed {
      logic [BT_W-1:0]   block_kind;
      logic [MASK_W-1:0] face_mask;
   } rsp_type;

endpackage

### sv/voxel_face_visibility_store_core.sv
`timescale 1ns / 1ps
// voxel_face_visibility_store_core: bordered voxel chunk with face culling queries.
// A write word is done as the back pops it while idle. A query pops while idle, issues
// one pair of reads on the two-read-port voxel memory there and in each of P1, P2 and P3,
// and forms the result in DONE, which waits for a free output register. Reset (synchronous,
// active high) starts a clearing pass over all (SIDE+2)^2*HEIGHT cells (20736 at defaults);
// req_tready stays low until the whole chunk reads as air.
module voxel_face_visibility_store_core
   import vfvs_pkg::*;
#(
   parameter int SIDE   = 16,
   parameter int HEIGHT = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // x[5:0], y[11:6], z[17:12], block_type[20:18]
   input  logic [0:0]             req_tuser,  // op[0]: 0 write, 1 query
   // response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata   // block_kind[2:0], face_mask[8:3]
);

   logic    fifo_full;
   logic    clearing;
   logic    push;
   cmd_type push_cmd;
   logic    pop;
   logic    head_valid;
   cmd_type head_cmd;
   rsp_type rsp_data;

   // Front: handshake and range check. Out-of-range words are accepted and dropped.
   vfvs_front #(
      .SIDE   (SIDE),
      .HEIGHT (HEIGHT)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .fifo_full  (fifo_full),
      .clearing   (clearing),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   // Queue: keeps the front taking words while the back works through a query.
   vfvs_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (fifo_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // Back: memory, clearing pass, query read sequence and output register.
   // Commands run strictly in order, so a write is always seen by later queries.
   vfvs_back #(
      .SIDE   (SIDE),
      .HEIGHT (HEIGHT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data)
   );

   assign rsp_tdata = {7'b0000000, rsp_data.face_mask, rsp_data.block_kind};

endmodule

### sv/vfvs_front.sv
`timescale 1ns / 1ps
// vfvs_front: accepts request words, range-checks and classifies them,
// and pushes the kept commands into the queue. Uses vfvs_pkg.
module vfvs_front
   import vfvs_pkg::*;
#(
   parameter int SIDE   = 16,
   parameter int HEIGHT = 64
) (
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [0:0]             req_tuser,
   input  logic                   fifo_full,
   input  logic                   clearing,
   output logic                   push,
   output cmd_type                push_cmd
);

   logic signed [COORD_W-1:0] xs;
   logic signed [COORD_W-1:0] ys;
   logic        [COORD_W-1:0] zu;
   logic                      z_ok;
   logic                      write_ok;
   logic                      query_ok;
   logic                      accept;

   assign xs = $signed(req_tdata[5:0]);
   assign ys = $signed(req_tdata[11:6]);
   assign zu = req_tdata[17:12];

   assign z_ok     = int'({1'b0, zu}) < HEIGHT;
   // border columns are writable, only interior columns are queryable
   assign write_ok = (xs >= -1) && (xs <= SIDE) && (ys >= -1) && (ys <= SIDE) && z_ok;
   assign query_ok = (xs >= 0) && (xs < SIDE) && (ys >= 0) && (ys < SIDE) && z_ok;

   assign req_tready = !fifo_full && !clearing;
   assign accept     = req_tvalid && req_tready;
   assign push       = accept && ((req_tuser[0] == OP_QUERY) ? query_ok : write_ok);

   assign push_cmd.op         = req_tuser[0];
   assign push_cmd.x          = req_tdata[5:0];
   assign push_cmd.y          = req_tdata[11:6];
   assign push_cmd.z          = zu;
   assign push_cmd.block_type = req_tdata[20:18];

endmodule

### sv/vfvs_fifo.sv
`timescale 1ns / 1ps
// vfvs_fifo: short command queue that decouples the front from the back.
// Uses vfvs_pkg for the command type and depth.
module vfvs_fifo
   import vfvs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type            slot_ff [FIFO_DEPTH];
   logic [FIFO_PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0] count_ff, count_in;

   assign full       = (count_ff == FIFO_CW'(FIFO_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### sv/vfvs_back.sv
`timescale 1ns / 1ps
// vfvs_back: voxel memory, clearing pass, write and query sequencer and the
// output register. Uses vfvs_pkg.
module vfvs_back
   import vfvs_pkg::*;
#(
   parameter int SIDE   = 16,
   parameter int HEIGHT = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    head_valid,
   input  cmd_type head_cmd,
   output logic    pop,
   output logic    clearing,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output rsp_type rsp_data
);

   localparam int ROW_SPAN = SIDE + 2;
   localparam int PLANE    = ROW_SPAN * HEIGHT;
   localparam int DEPTH    = ROW_SPAN * ROW_SPAN * HEIGHT;
   localparam int AW       = $clog2(DEPTH);
   localparam int XW       = $clog2(ROW_SPAN);
   localparam int ZW       = $clog2(HEIGHT);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_P1    = 3'd2;
   localparam logic [2:0] ST_P2    = 3'd3;
   localparam logic [2:0] ST_P3    = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] cx,
                                              input logic [XW-1:0] cy,
                                              input logic [ZW-1:0] cz);
      cell_addr = AW'(cx) * AW'(PLANE) + AW'(cy) * AW'(HEIGHT) + AW'(cz);
   endfunction

   logic [BT_W-1:0]   voxel_mem [DEPTH];
   logic [BT_W-1:0]   rd_a_ff, rd_b_ff;

   logic [2:0]        state_ff, state_in;
   logic [AW-1:0]     clr_ff, clr_in;
   cmd_type           cmd_ff, cmd_in;
   logic [BT_W-1:0]   kind_ff, kind_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_data_ff, out_data_in;

   cmd_type           cur;
   logic [6:0]        xs7, ys7;
   logic [8:0]        z9;
   logic [XW-1:0]     xi, yi;
   logic [ZW-1:0]     zi, zp, zm;
   logic              top, bottom;
   logic [AW-1:0]     a_center, a_ym, a_yp, a_xm, a_xp, a_zp, a_zm;
   logic [AW-1:0]     addr_a, addr_b, waddr;
   logic [BT_W-1:0]   wdata;
   logic              mem_we, mem_re;
   logic              slot_free;
   logic [MASK_W-1:0] mask_full;

   // coordinates come from the queue head while idle, else from the held command
   assign cur    = (state_ff == ST_IDLE) ? head_cmd : cmd_ff;
   assign xs7    = {cur.x[COORD_W-1], cur.x} + 7'd1;
   assign ys7    = {cur.y[COORD_W-1], cur.y} + 7'd1;
   assign xi     = xs7[XW-1:0];
   assign yi     = ys7[XW-1:0];
   assign z9     = {3'b000, cur.z};
   assign zi     = z9[ZW-1:0];
   assign top    = (z9 == 9'(HEIGHT - 1));
   assign bottom = (cur.z == '0);
   assign zp     = top ? zi : zi + ZW'(1);
   assign zm     = bottom ? zi : zi - ZW'(1);

   assign a_center = cell_addr(xi, yi, zi);
   assign a_ym     = cell_addr(xi, yi - XW'(1), zi);
   assign a_yp     = cell_addr(xi, yi + XW'(1), zi);
   assign a_xm     = cell_addr(xi - XW'(1), yi, zi);
   assign a_xp     = cell_addr(xi + XW'(1), yi, zi);
   assign a_zp     = cell_addr(xi, yi, zp);
   assign a_zm     = cell_addr(xi, yi, zm);

   assign clearing  = (state_ff == ST_CLEAR);
   assign pop       = (state_ff == ST_IDLE) && head_valid;
   assign slot_free = !out_valid_ff || rsp_tready;

   always_comb begin
      addr_a = a_center;
      addr_b = a_ym;
      unique case (state_ff)
         ST_P1: begin
            addr_a = a_yp;
            addr_b = a_xm;
         end
         ST_P2: begin
            addr_a = a_xp;
            addr_b = a_zp;
         end
         ST_P3: begin
            addr_a = a_zm;
            addr_b = a_center;
         end
         default: begin
            addr_a = a_center;
            addr_b = a_ym;
         end
      endcase
   end

   assign mem_re = (pop && (head_cmd.op == OP_QUERY)) || (state_ff == ST_P1)
                   || (state_ff == ST_P2) || (state_ff == ST_P3);
   assign mem_we = clearing || (pop && (head_cmd.op == OP_WRITE));
   assign waddr  = clearing ? clr_ff : a_center;
   assign wdata  = clearing ? '0 : head_cmd.block_type;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         voxel_mem[waddr] <= wdata;
      end
      if (mem_re) begin
         rd_a_ff <= voxel_mem[addr_a];
         rd_b_ff <= voxel_mem[addr_b];
      end
   end

   always_comb begin
      mask_full = mask_ff;
      mask_full[FACE_ZM] = !bottom && (rd_a_ff == '0);
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cmd_in       = cmd_ff;
      kind_in      = kind_ff;
      mask_in      = mask_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (pop && (head_cmd.op == OP_QUERY)) begin
               cmd_in   = head_cmd;
               state_in = ST_P1;
            end
         end
         ST_P1: begin
            kind_in          = rd_a_ff;
            mask_in          = '0;
            mask_in[FACE_YM] = (rd_b_ff == '0);
            state_in         = ST_P2;
         end
         ST_P2: begin
            mask_in[FACE_YP] = (rd_a_ff == '0);
            mask_in[FACE_XM] = (rd_b_ff == '0);
            state_in         = ST_P3;
         end
         ST_P3: begin
            mask_in[FACE_XP] = (rd_a_ff == '0);
            mask_in[FACE_ZP] = top || (rd_b_ff == '0);
            state_in         = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               out_valid_in          = 1'b1;
               out_data_in.block_kind = kind_ff;
               out_data_in.face_mask  = (kind_ff != '0) ? mask_full : '0;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      kind_ff     <= kind_in;
      mask_ff     <= mask_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_data   = out_data_ff;

endmodule
